### rtl/core/led_frame_serial_receiver_top_assert.svh
`ifndef LED_FRAME_SERIAL_RECEIVER_TOP_ASSERT_SVH
`define LED_FRAME_SERIAL_RECEIVER_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define LFR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("led frame receiver check failed");

// Implication checked in the next cycle.
`define LFR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("led frame receiver check failed");

`endif

### rtl/core/lfr_pkg.sv
package lfr_pkg;

  localparam int MAX_PIXELS = 1024;
  localparam int MEM_DEPTH  = 2 * MAX_PIXELS;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int LEN_W      = 17;

  localparam logic [7:0]  MAGIC_0    = 8'h41;
  localparam logic [7:0]  MAGIC_1    = 8'h64;
  localparam logic [7:0]  MAGIC_2    = 8'h61;
  localparam logic [7:0]  CHECK_XOR  = 8'h55;
  localparam logic [31:0] HASH_CONST = 32'h9e3779b9;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_MAGIC2,
    PH_HIGH,
    PH_LOW,
    PH_CHECK,
    PH_BODY,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_NONE,
    STATUS_ACCEPTED,
    STATUS_MISMATCH,
    STATUS_TOO_LARGE
  } status_t;

  typedef struct packed {
    logic        is_read;
    logic        index_ok;
    logic [7:0]  rx_byte;
    logic [15:0] pixel_index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [31:0] lfr_mix(logic [31:0] sum, logic [23:0] rgb);
    logic [31:0] h;
    h = {rgb[23:16], rgb[15:8], 8'h00, rgb[7:0]};
    return (sum + HASH_CONST + {h[25:0], 6'b0} + {2'b0, h[31:2]}) ^ h;
  endfunction

endpackage

### rtl/core/lfr_if.sv
interface lfr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  rx_byte;
  logic [15:0] pixel_index;

  modport source (output valid, mode, rx_byte, pixel_index, input ready);
  modport sink (input valid, mode, rx_byte, pixel_index, output ready);
endinterface

interface lfr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;
  logic [1:0]  frame_status;
  logic        receiving;
  logic [16:0] shown_length;

  modport source (output valid, pixel_rgb, frame_status, receiving, shown_length,
                  input ready);
  modport sink (input valid, pixel_rgb, frame_status, receiving, shown_length,
                output ready);
endinterface

### rtl/core/lfr_front.sv
module lfr_front (
  input  logic            clk,
  input  logic            rst,
  lfr_in_if.sink          request,
  output lfr_pkg::head_t  head,
  input  logic            pop
);
  import lfr_pkg::*;

  cmd_t       slot [2];
  cmd_t       cmd;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       accept;

  assign request.ready = (count != 2'd2);
  assign accept        = request.valid && request.ready;

  always_comb begin
    cmd.is_read     = (request.mode == MODE_READ);
    cmd.index_ok    = ({1'b0, request.pixel_index} < LEN_W'(MAX_PIXELS));
    cmd.rx_byte     = request.rx_byte;
    cmd.pixel_index = request.pixel_index;
  end

  always_comb begin
    case ({accept, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) slot[wr_ptr] <= cmd;
  end

endmodule

### rtl/core/lfr_back.sv
module lfr_back (
  input  logic            clk,
  input  logic            rst,
  input  lfr_pkg::head_t  head,
  output logic            pop,
  lfr_out_if.source       response
);
  import lfr_pkg::*;

  logic [23:0] mem [MEM_DEPTH];
  logic [23:0] mem_q;

  phase_t      phase, phase_next;
  logic [7:0]  count_high, count_high_next;
  logic [15:0] frame_count, frame_count_next;
  logic [15:0] cursor, cursor_next;
  logic [1:0]  comp, comp_next;
  logic [15:0] partial, partial_next;
  logic [31:0] hash, hash_next;
  logic [23:0] rcheck, rcheck_next;
  logic        front_bank, front_bank_next;
  logic [16:0] front_length, front_length_next;
  status_t     status;

  logic              take_byte;
  logic [7:0]        rx;
  logic [23:0]       rgb;
  logic              wr_en;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              read_hit;

  logic        s1_valid;
  logic        s1_adv;
  logic        s1_hit;
  status_t     s1_status;
  logic        s1_receiving;
  logic [16:0] s1_length;

  logic        out_valid;
  logic [23:0] out_rgb;
  status_t     out_status;
  logic        out_receiving;
  logic [16:0] out_length;

  assign s1_adv    = !out_valid || response.ready;
  assign pop       = head.valid && (!s1_valid || s1_adv);
  assign take_byte = pop && !head.cmd.is_read;
  assign rx        = head.cmd.rx_byte;
  assign rgb       = {partial, rx};

  always_comb begin
    phase_next        = phase;
    count_high_next   = count_high;
    frame_count_next  = frame_count;
    cursor_next       = cursor;
    comp_next         = comp;
    partial_next      = partial;
    hash_next         = hash;
    rcheck_next       = rcheck;
    front_bank_next   = front_bank;
    front_length_next = front_length;
    status            = STATUS_NONE;
    wr_en             = 1'b0;
    if (take_byte) begin
      case (phase)
        PH_MAGIC0: phase_next = (rx == MAGIC_0) ? PH_MAGIC1 : PH_MAGIC0;
        PH_MAGIC1: phase_next = (rx == MAGIC_1) ? PH_MAGIC2 : PH_MAGIC0;
        PH_MAGIC2: phase_next = (rx == MAGIC_2) ? PH_HIGH : PH_MAGIC0;
        PH_HIGH: begin
          count_high_next = rx;
          phase_next      = PH_LOW;
        end
        PH_LOW: begin
          frame_count_next = {count_high, rx};
          phase_next       = PH_CHECK;
        end
        PH_CHECK: begin
          if (rx == (count_high ^ frame_count[7:0] ^ CHECK_XOR)) begin
            cursor_next  = 16'd0;
            comp_next    = 2'd0;
            partial_next = 16'd0;
            hash_next    = 32'd0;
            rcheck_next  = 24'd0;
            phase_next   = PH_BODY;
          end else begin
            phase_next = PH_MAGIC0;
          end
        end
        PH_BODY: begin
          if (comp < 2'd2) begin
            partial_next = {partial[7:0], rx};
            comp_next    = comp + 2'd1;
          end else begin
            hash_next    = lfr_mix(hash, rgb);
            wr_en        = ({1'b0, cursor} < LEN_W'(MAX_PIXELS));
            comp_next    = 2'd0;
            partial_next = 16'd0;
            if (cursor == frame_count) begin
              phase_next = PH_SUM;
            end else begin
              cursor_next = cursor + 16'd1;
            end
          end
        end
        PH_SUM: begin
          case (comp)
            2'd0: begin
              rcheck_next[7:0] = rx;
              comp_next        = 2'd1;
            end
            2'd1: begin
              rcheck_next[15:8] = rx;
              comp_next         = 2'd2;
            end
            2'd2: begin
              rcheck_next[23:16] = rx;
              comp_next          = 2'd3;
            end
            default: begin
              if ({1'b0, frame_count} >= LEN_W'(MAX_PIXELS)) begin
                status = STATUS_TOO_LARGE;
              end else if ({rx, rcheck} != hash) begin
                status = STATUS_MISMATCH;
              end else begin
                status            = STATUS_ACCEPTED;
                front_bank_next   = ~front_bank;
                front_length_next = {1'b0, frame_count} + 17'd1;
              end
              comp_next   = 2'd0;
              rcheck_next = 24'd0;
              phase_next  = PH_MAGIC0;
            end
          endcase
        end
        default: phase_next = PH_MAGIC0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC0;
      count_high   <= 8'd0;
      frame_count  <= 16'd0;
      cursor       <= 16'd0;
      comp         <= 2'd0;
      partial      <= 16'd0;
      hash         <= 32'd0;
      rcheck       <= 24'd0;
      front_bank   <= 1'b0;
      front_length <= 17'd0;
    end else begin
      phase        <= phase_next;
      count_high   <= count_high_next;
      frame_count  <= frame_count_next;
      cursor       <= cursor_next;
      comp         <= comp_next;
      partial      <= partial_next;
      hash         <= hash_next;
      rcheck       <= rcheck_next;
      front_bank   <= front_bank_next;
      front_length <= front_length_next;
    end
  end

  assign waddr = ADDR_W'(cursor) + (front_bank ? ADDR_W'(0) : ADDR_W'(MAX_PIXELS));
  assign raddr = ADDR_W'(head.cmd.pixel_index)
               + (front_bank ? ADDR_W'(MAX_PIXELS) : ADDR_W'(0));
  assign read_hit = head.cmd.is_read && head.cmd.index_ok
                 && ({1'b0, head.cmd.pixel_index} < front_length);

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= rgb;
    if (pop) mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_hit       <= read_hit;
      s1_status    <= status;
      s1_receiving <= (phase_next == PH_BODY) || (phase_next == PH_SUM);
      s1_length    <= front_length_next;
    end
    if (s1_adv && s1_valid) begin
      out_rgb       <= s1_hit ? mem_q : 24'd0;
      out_status    <= s1_status;
      out_receiving <= s1_receiving;
      out_length    <= s1_length;
    end
  end

  assign response.valid        = out_valid;
  assign response.pixel_rgb    = out_rgb;
  assign response.frame_status = out_status;
  assign response.receiving    = out_receiving;
  assign response.shown_length = out_length;

endmodule

### rtl/core/led_frame_serial_receiver_top.sv
// Serial LED frame receiver with a double-buffered pixel store.
// request: one transaction per item; mode 0 feeds a received serial byte
//   (rx_byte), mode 1 reads the displayed pixel at pixel_index.
// response: exactly one transaction per request, in order, carrying the
//   read pixel (zero for bytes and for reads past the shown length), the
//   frame status on the byte that ends a frame, the receiving flag and the
//   shown length, both as left by that item.
// Path: each request is held in the queue, then registered in stage 1 and in the output register.
// Throughput: one item per cycle while response is ready; every byte updates
//   the parser and may do one store write, and every item does one store read,
//   on a single-write, single-read pixel memory.
// Reset: the parser searches for the first magic byte, the shown length is
//   zero and every read returns zero until a frame is accepted; the pixel
//   store itself is not cleared.
// Stall: the response holds while ready is low; a two-entry queue takes up
//   to two further requests, then request ready drops.
module led_frame_serial_receiver_top (
  input  logic      clk,
  input  logic      rst,
  lfr_in_if.sink    request,
  lfr_out_if.source response
);
  import lfr_pkg::*;

  head_t head;
  logic  pop;

  lfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .head    (head),
    .pop     (pop)
  );

  lfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .response (response)
  );

endmodule

### rtl/core/lfr_checker.sv
`include "led_frame_serial_receiver_top_assert.svh"

module lfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_rgb,
  input logic [1:0]  frame_status,
  input logic        receiving,
  input logic [16:0] shown_length
);
  import lfr_pkg::*;

  `LFR_ASSERT_IMPL(a_end_not_receiving, out_valid && (frame_status != STATUS_NONE), !receiving)
  `LFR_ASSERT_IMPL(a_end_no_pixel, out_valid && (frame_status != STATUS_NONE), pixel_rgb == 24'd0)
  `LFR_ASSERT_IMPL(a_accept_length, out_valid && (frame_status == STATUS_ACCEPTED), shown_length != 17'd0)
  `LFR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(shown_length))

endmodule

bind led_frame_serial_receiver_top lfr_checker u_lfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (response.valid),
  .out_ready    (response.ready),
  .pixel_rgb    (response.pixel_rgb),
  .frame_status (response.frame_status),
  .receiving    (response.receiving),
  .shown_length (response.shown_length)
);

### verif/tb_led_frame_serial_receiver_top.sv
module tb_led_frame_serial_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RAND_ITEMS  = 600;

  typedef struct packed {
    logic [23:0] rgb;
    status_t     status;
    logic        receiving;
    logic [16:0] shown;
  } pixel_reply_t;

  class frame_tracker;
    phase_t       phase      = PH_MAGIC0;
    logic [7:0]   count_hi   = '0;
    logic [16:0]  frame_len  = '0;
    logic [15:0]  cursor     = '0;
    logic [1:0]   slot       = '0;
    logic [15:0]  partial    = '0;
    logic [31:0]  hash       = '0;
    logic [23:0]  sum_bytes  = '0;
    logic [23:0]  pixels [MEM_DEPTH];
    logic         bank       = 1'b0;
    logic [16:0]  shown_len  = '0;
    pixel_reply_t replies_due[$];
    int           errors     = 0;

    static function logic [31:0] fold_pixel(logic [31:0] acc, logic [23:0] rgb);
      logic [31:0] h;
      h = {rgb[23:16], 24'h0} + {8'h0, rgb[15:8], 16'h0} + {24'h0, rgb[7:0]};
      return (acc + HASH_CONST + (h << 6) + (h >> 2)) ^ h;
    endfunction

    function status_t feed_byte(logic [7:0] b);
      status_t     st;
      logic [16:0] last;
      logic [23:0] rgb;
      logic [31:0] full;
      st = STATUS_NONE;
      last = frame_len - 17'd1;
      case (phase)
        PH_MAGIC0: phase = (b == MAGIC_0) ? PH_MAGIC1 : PH_MAGIC0;
        PH_MAGIC1: phase = (b == MAGIC_1) ? PH_MAGIC2 : PH_MAGIC0;
        PH_MAGIC2: phase = (b == MAGIC_2) ? PH_HIGH : PH_MAGIC0;
        PH_HIGH: begin
          count_hi = b;
          phase = PH_LOW;
        end
        PH_LOW: begin
          frame_len = {1'b0, count_hi, b} + 17'd1;
          phase = PH_CHECK;
        end
        PH_CHECK: begin
          if (b == (count_hi ^ last[7:0] ^ CHECK_XOR)) begin
            cursor = '0;
            slot = '0;
            partial = '0;
            hash = '0;
            sum_bytes = '0;
            phase = PH_BODY;
          end else begin
            phase = PH_MAGIC0;
          end
        end
        PH_BODY: begin
          if (slot < 2) begin
            partial = {partial[7:0], b};
            slot++;
          end else begin
            rgb = {partial, b};
            hash = fold_pixel(hash, rgb);
            if (cursor < MAX_PIXELS)
              pixels[(bank ? 0 : MAX_PIXELS) + int'(cursor)] = rgb;
            slot = '0;
            partial = '0;
            if (cursor == last[15:0])
              phase = PH_SUM;
            else
              cursor++;
          end
        end
        default: begin
          if (slot < 3) begin
            sum_bytes = {b, sum_bytes[23:8]};
            slot++;
          end else begin
            full = {b, sum_bytes};
            if (frame_len > MAX_PIXELS) begin
              st = STATUS_TOO_LARGE;
            end else if (full != hash) begin
              st = STATUS_MISMATCH;
            end else begin
              st = STATUS_ACCEPTED;
              bank = ~bank;
              shown_len = frame_len;
            end
            slot = '0;
            sum_bytes = '0;
            phase = PH_MAGIC0;
          end
        end
      endcase
      return st;
    endfunction

    function void note_request(logic mode, logic [7:0] b, logic [15:0] idx);
      pixel_reply_t r;
      r.rgb = '0;
      r.status = STATUS_NONE;
      if (mode == MODE_BYTE)
        r.status = feed_byte(b);
      else if (idx < shown_len && idx < MAX_PIXELS)
        r.rgb = pixels[(bank ? MAX_PIXELS : 0) + int'(idx)];
      r.receiving = (phase == PH_BODY || phase == PH_SUM);
      r.shown = shown_len;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [23:0] rgb, logic [1:0] status, logic receiving,
                              logic [16:0] shown);
      pixel_reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected response rgb %06h status %0d", $time, rgb, status);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      if (r.rgb !== rgb) begin
        $display("%0t: pixel_rgb expected %06h actual %06h", $time, r.rgb, rgb);
        errors++;
      end
      if (r.status !== status) begin
        $display("%0t: frame_status expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (r.receiving !== receiving) begin
        $display("%0t: receiving expected %0b actual %0b", $time, r.receiving, receiving);
        errors++;
      end
      if (r.shown !== shown) begin
        $display("%0t: shown_length expected %0d actual %0d", $time, r.shown, shown);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   quiet = 1'b0;
  int   items_sent = 0;
  int   cycle_count = 0;
  frame_tracker tracker;

  lfr_in_if  request_if();
  lfr_out_if response_if();

  led_frame_serial_receiver_top u_top (
    .clk      (clk),
    .rst      (rst),
    .request  (request_if),
    .response (response_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    response_if.ready <= !rst && (quiet || $urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst && response_if.valid && response_if.ready)
      tracker.check_reply(response_if.pixel_rgb, response_if.frame_status,
                          response_if.receiving, response_if.shown_length);
  end

  function automatic bit take_break();
    return !quiet && $urandom_range(0, 99) < 36;
  endfunction

  function automatic logic [15:0] pick_index();
    if ($urandom_range(0, 9) < 7)
      return 16'($urandom_range(0, tracker.shown_len));
    return 16'($urandom_range(0, 65535));
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(logic mode, logic [7:0] b, logic [15:0] idx);
    while (take_break()) begin
      request_if.valid = 1'b0;
      @(negedge clk);
    end
    request_if.valid       = 1'b1;
    request_if.mode        = mode;
    request_if.rx_byte     = b;
    request_if.pixel_index = idx;
    do @(posedge clk); while (!request_if.ready);
    tracker.note_request(mode, b, idx);
    items_sent++;
    @(negedge clk);
    request_if.valid = 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(MODE_BYTE, b, 16'($urandom));
  endtask

  task automatic send_read(logic [15:0] idx);
    send_item(MODE_READ, 8'($urandom), idx);
  endtask

  task automatic send_frame(int unsigned count, bit corrupt, int read_pct);
    logic [7:0]  stream[$];
    logic [31:0] sum;
    logic [23:0] rgb;
    logic [7:0]  hi;
    logic [7:0]  lo;
    hi = count[15:8];
    lo = count[7:0];
    stream = {MAGIC_0, MAGIC_1, MAGIC_2, hi, lo, hi ^ lo ^ CHECK_XOR};
    sum = '0;
    for (int i = 0; i <= int'(count); i++) begin
      rgb = 24'($urandom);
      stream.push_back(rgb[23:16]);
      stream.push_back(rgb[15:8]);
      stream.push_back(rgb[7:0]);
      sum = frame_tracker::fold_pixel(sum, rgb);
    end
    if (corrupt)
      sum = sum ^ (32'h1 << $urandom_range(0, 31));
    stream.push_back(sum[7:0]);
    stream.push_back(sum[15:8]);
    stream.push_back(sum[23:16]);
    stream.push_back(sum[31:24]);
    foreach (stream[i]) begin
      if ($urandom_range(0, 99) < read_pct)
        send_read(pick_index());
      send_byte(stream[i]);
    end
  endtask

  task automatic send_broken_header(logic [7:0] hi, logic [7:0] lo, int cut);
    logic [7:0] good[6];
    good = '{MAGIC_0, MAGIC_1, MAGIC_2, hi, lo, hi ^ lo ^ CHECK_XOR};
    for (int i = 0; i < 6; i++) begin
      if (i == cut) begin
        send_byte(good[i] ^ 8'($urandom_range(1, 255)));
        break;
      end
      send_byte(good[i]);
    end
  endtask

  task automatic wait_all_replies();
    while (tracker.replies_due.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int  rand_base;
    int  pick;
    bit  paused;
    tracker = new();
    rst = 1'b1;
    request_if.valid = 1'b0;
    request_if.mode = MODE_BYTE;
    request_if.rx_byte = '0;
    request_if.pixel_index = '0;
    response_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_read(16'h0000);
    send_read(16'hFFFF);
    send_byte(MAGIC_0);
    send_byte(MAGIC_0);
    send_byte(MAGIC_1);
    send_byte(MAGIC_2);
    send_broken_header(8'hFF, 8'hFF, 5);
    send_broken_header(8'h00, 8'h00, 5);
    send_frame(0, 1'b0, 0);
    send_read(16'h0000);
    send_read(16'h0001);
    send_frame(2, 1'b1, 30);
    send_read(16'h0000);
    send_read(16'(MAX_PIXELS - 1));
    send_read(16'(MAX_PIXELS));
    send_read(16'hFFFF);
    wait_all_replies();

    rand_base = items_sent;
    paused = 1'b0;
    while (items_sent - rand_base < RAND_ITEMS) begin
      quiet = (items_sent - rand_base >= 150) && (items_sent - rand_base < 300);
      if (!paused && items_sent - rand_base >= 400) begin
        wait_all_replies();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame($urandom_range(0, 7), $urandom_range(0, 4) == 0, 15);
      end else if (pick < 67) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 80) begin
        send_broken_header(8'($urandom), 8'($urandom), $urandom_range(0, 5));
      end else begin
        repeat ($urandom_range(1, 6)) send_read(pick_index());
      end
    end
    quiet = 1'b0;
    request_if.valid = 1'b0;

    wait_all_replies();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
